[hw/rtl/teafh_pkg.sv]
package teafh_pkg;

    localparam int MAX_NAME_LEN = 255;
    localparam int TEA_ROUNDS   = 16;
    localparam int RND_W        = $clog2(TEA_ROUNDS + 1);
    localparam int CHUNK_BYTES  = 16;
    localparam int Q_DEPTH      = 2;

    localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;
    localparam logic [31:0] INIT_W0   = 32'h67452301;
    localparam logic [31:0] INIT_W1   = 32'hEFCDAB89;
    localparam logic [7:0]  DOT_CHAR  = 8'h2E;

    // One chunk handed from the byte packer to the TEA unit
    typedef struct packed {
        logic [3:0][31:0] words;
        logic             first;   // first chunk of a name: reload running words
        logic             last;    // final chunk: emit the hash afterwards
        logic             dot;     // name is "." or "..": hash forced to zero
    } teafh_job_t;

    // Status of the TEA unit
    typedef struct packed {
        logic busy;
        logic fin_last;   // final round of a name's last chunk retires this cycle
    } teafh_bstat_t;

    // Repeat the remaining-length byte across a word
    function automatic logic [31:0] pad_word(input logic [7:0] r);
        return {4{r}};
    endfunction

endpackage

[hw/rtl/teafh_front.sv]
module teafh_front
    import teafh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       name_byte,
    input  logic [7:0]       name_length,
    input  logic             last_byte,
    output logic             push,
    output teafh_job_t       job
);

    logic             in_name_reg, in_name_next;
    logic             first_reg, first_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       held_reg, held_next;
    logic [1:0]       dot_reg, dot_next;
    logic [3:0][31:0] words_reg, words_next;

    logic             start;
    logic [7:0]       len_c;
    logic             b_first;
    logic [3:0]       b_cnt;
    logic [7:0]       b_rem;
    logic [7:0]       b_held;
    logic [1:0]       b_dot;
    logic [3:0][31:0] b_words;
    logic [3:0][31:0] w_upd;
    logic [1:0]       d_upd;
    logic [7:0]       rem_sat;
    logic [1:0]       widx;

    // Pick up the name start or the running chunk, then fold in the byte
    always_comb
    begin
        start = !in_name_reg;
        len_c = (name_length > 8'(MAX_NAME_LEN)) ? 8'(MAX_NAME_LEN) : name_length;

        b_first = start ? 1'b1 : first_reg;
        b_cnt   = start ? 4'd0 : cnt_reg;
        b_rem   = start ? len_c : rem_reg;
        b_held  = start ? len_c : held_reg;
        b_dot   = start ? 2'b00 : dot_reg;
        b_words = start ? {4{pad_word(len_c)}} : words_reg;

        widx        = b_cnt[3:2];
        w_upd       = b_words;
        w_upd[widx] = {b_words[widx][23:0], name_byte};

        d_upd = b_dot;
        if (b_first && (b_cnt == 4'd0) && (name_byte == DOT_CHAR))
        begin
            d_upd[0] = 1'b1;
        end
        if (b_first && (b_cnt == 4'd1) && (name_byte == DOT_CHAR))
        begin
            d_upd[1] = 1'b1;
        end

        rem_sat = (b_rem > 8'(CHUNK_BYTES)) ? (b_rem - 8'(CHUNK_BYTES)) : 8'd0;

        in_name_next = in_name_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        held_next    = held_reg;
        dot_next     = dot_reg;
        words_next   = words_reg;

        push      = 1'b0;
        job.words = w_upd;
        job.first = b_first;
        job.last  = 1'b0;
        job.dot   = 1'b0;

        if (accept)
        begin
            if (start && (len_c == 8'd0))
            begin
                // Empty name: one all-zero chunk, done at once
                push         = 1'b1;
                job.words    = {4{pad_word(8'd0)}};
                job.first    = 1'b1;
                job.last     = 1'b1;
                in_name_next = 1'b0;
            end
            else if (last_byte)
            begin
                push         = 1'b1;
                job.last     = 1'b1;
                job.dot      = ((b_held == 8'd1) && d_upd[0]) ||
                               ((b_held == 8'd2) && (d_upd == 2'b11));
                in_name_next = 1'b0;
            end
            else if (b_cnt == 4'(CHUNK_BYTES - 1))
            begin
                // Chunk full: hand it off and refill from the new remainder
                push         = 1'b1;
                in_name_next = 1'b1;
                first_next   = 1'b0;
                cnt_next     = 4'd0;
                rem_next     = rem_sat;
                held_next    = b_held;
                dot_next     = d_upd;
                words_next   = {4{pad_word(rem_sat)}};
            end
            else
            begin
                in_name_next = 1'b1;
                first_next   = b_first;
                cnt_next     = b_cnt + 4'd1;
                rem_next     = b_rem;
                held_next    = b_held;
                dot_next     = d_upd;
                words_next   = w_upd;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_name_reg <= 1'b0;
        end
        else
        begin
            in_name_reg <= in_name_next;
        end
    end

    // Chunk payload
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        held_reg  <= held_next;
        dot_reg   <= dot_next;
        words_reg <= words_next;
    end

endmodule

[hw/rtl/teafh_queue.sv]
module teafh_queue
    import teafh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  teafh_job_t push_job,
    input  logic       pop,
    output logic       full,
    output logic       avail,
    output teafh_job_t head
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    teafh_job_t         mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    // Advance pointers and occupancy
    always_comb
    begin
        full    = (cnt_reg == CNT_W'(Q_DEPTH));
        avail   = (cnt_reg != '0);
        head    = mem[rd_reg];
        do_push = push && !full;
        do_pop  = pop && avail;

        wr_next  = do_push ? ((wr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/teafh_back.sv]
module teafh_back
    import teafh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  teafh_job_t   job,
    output logic         job_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  out_hash,
    output teafh_bstat_t stat
);

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(TEA_ROUNDS - 1);

    logic             busy_reg, busy_next;
    logic             ovalid_reg, ovalid_next;
    logic [31:0]      ohash_reg, ohash_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [31:0]      v0_reg, v0_next;
    logic [31:0]      v1_reg, v1_next;
    logic [31:0]      sum_reg, sum_next;
    logic [31:0]      run0_reg, run0_next;
    logic [31:0]      run1_reg, run1_next;
    logic [3:0][31:0] key_reg, key_next;
    logic             last_reg, last_next;
    logic             dot_reg, dot_next;

    logic        out_free;
    logic        at_end;
    logic        advance;
    logic        fin;
    logic        load;
    logic [31:0] v0_rnd;
    logic [31:0] v1_rnd;
    logic [31:0] run0_cur;
    logic [31:0] run1_cur;

    // One TEA round per cycle unless output full; sum_reg has its delta
    always_comb
    begin
        v0_rnd = v0_reg + (((v1_reg << 4) + key_reg[0]) ^ (v1_reg + sum_reg) ^
                           ((v1_reg >> 5) + key_reg[1]));
        v1_rnd = v1_reg + (((v0_rnd << 4) + key_reg[2]) ^ (v0_rnd + sum_reg) ^
                           ((v0_rnd >> 5) + key_reg[3]));
    end

    // Sequence rounds, retire chunks, load the next chunk
    always_comb
    begin
        out_free = !ovalid_reg || out_ready;
        at_end   = busy_reg && (rnd_reg == LAST_RND);
        advance  = busy_reg && !(at_end && last_reg && !out_free);
        fin      = at_end && advance;
        load     = job_valid && (!busy_reg || fin);
        job_pop  = load;

        run0_cur = fin ? (run0_reg + v0_rnd) : run0_reg;
        run1_cur = fin ? (run1_reg + v1_rnd) : run1_reg;

        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        sum_next  = sum_reg;
        run0_next = run0_cur;
        run1_next = run1_cur;
        key_next  = key_reg;
        last_next = last_reg;
        dot_next  = dot_reg;

        if (advance)
        begin
            rnd_next = rnd_reg + 1'b1;
            v0_next  = v0_rnd;
            v1_next  = v1_rnd;
            sum_next = sum_reg + TEA_DELTA;
        end
        if (fin)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            sum_next  = TEA_DELTA;
            run0_next = job.first ? INIT_W0 : run0_cur;
            run1_next = job.first ? INIT_W1 : run1_cur;
            v0_next   = job.first ? INIT_W0 : run0_cur;
            v1_next   = job.first ? INIT_W1 : run1_cur;
            key_next  = job.words;
            last_next = job.last;
            dot_next  = job.dot;
        end

        // Output register: hold until taken
        ovalid_next = ovalid_reg && !out_ready;
        ohash_next  = ohash_reg;
        if (fin && last_reg)
        begin
            ovalid_next = 1'b1;
            ohash_next  = dot_reg ? 32'd0 : run0_cur;
        end

        out_valid     = ovalid_reg;
        out_hash      = ohash_reg;
        stat.busy     = busy_reg;
        stat.fin_last = fin && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg   <= rnd_next;
        v0_reg    <= v0_next;
        v1_reg    <= v1_next;
        sum_reg   <= sum_next;
        run0_reg  <= run0_next;
        run1_reg  <= run1_next;
        key_reg   <= key_next;
        last_reg  <= last_next;
        dot_reg   <= dot_next;
        ohash_reg <= ohash_next;
    end

endmodule

[hw/rtl/tea_filename_hash_top.sv]
// Throughput: one name byte per cycle unless the 2-chunk queue is full; the TEA unit runs one round per
// cycle unless a finished hash is waiting on the output, and each 16-byte chunk (or short name) takes
// 16 rounds; a name needs ceil(max(len,1)/16) chunks, and the next chunk loads as the last round retires.
// Reset: rst_n asynchronous, active low; clears name tracking, queue, TEA busy and output valid.
// No clearing pass; the block accepts bytes in the first cycle after reset.
module tea_filename_hash_top
    import teafh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] name_byte, [15:8] name_length
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    logic         s_accept;
    logic         q_push;
    teafh_job_t   q_in;
    logic         q_full;
    logic         q_avail;
    teafh_job_t   q_head;
    logic         q_pop;
    teafh_bstat_t bstat;

    // Take a beat only when the queue can hold a chunk
    assign s_axis_tready = !q_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    teafh_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .name_byte   (s_axis_tdata[7:0]),
        .name_length (s_axis_tdata[15:8]),
        .last_byte   (s_axis_tlast),
        .push        (q_push),
        .job         (q_in)
    );

    teafh_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .full     (q_full),
        .avail    (q_avail),
        .head     (q_head)
    );

    teafh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_avail),
        .job       (q_head),
        .job_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata),
        .stat      (bstat)
    );

`ifndef ASSERT_OFF
    // A chunk is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("chunk pushed into full queue");

    // The last byte of a name always hands a chunk to the queue
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tlast) |-> q_push)
        else $error("last byte did not produce a chunk");

    // A new result only follows the final round of a name's last chunk
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |-> $past(bstat.fin_last))
        else $error("result without a finished name");
`endif

endmodule
